@@ rtl/cll_pkg.sv @@
// Shared constants, types and a helper function for the cursor linked list engine.
package cll_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int CAPACITY   = SLOTS - 2;
  localparam int HEAD_SLOT  = SLOTS - 1;
  localparam int FREE_SLOT  = 0;
  localparam int DATA_BITS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 7;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic [SLOT_BITS-1:0] slot_t;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_RA,
    S_RB,
    S_RC,
    S_W1,
    S_W2,
    S_W3,
    S_ERR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_HEAD,
    RA_LINK,
    RA_FREE
  } ra_sel_t;

  typedef enum logic [1:0] {
    WA_FREE,
    WA_PREV,
    WA_A,
    WA_F
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_A,
    WD_B,
    WD_F
  } wd_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       walk_start;
    logic       walk_step;
    logic       prev_head;
    logic       prev_link;
    logic       rd_en;
    ra_sel_t    ra_sel;
    logic       ld_a;
    logic       ld_b;
    logic       ld_f;
    logic       wr_en;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    logic       data_wr;
    logic       data_rd;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_data;
  } cll_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       err_range;
    logic       full;
    logic       steps_zero;
    logic       left_one;
    logic       out_free;
  } cll_sts_t;

  // Link value that a slot holds right after reset.
  function automatic slot_t reset_link(slot_t s);
    return (int'(s) < CAPACITY) ? slot_t'(int'(s) + 1) : slot_t'(FREE_SLOT);
  endfunction

endpackage

@@ rtl/cursor_linked_list_engine_unit.sv @@
// Top level of the cursor linked list engine: controller, datapath and checks.
// The input channel (in_valid, in_ready) takes one transaction per operation:
// mode selects insert after a position (0 is the front), delete at a position
// or read at a position, and value is the word that an insert stores.
// The output channel (out_valid, out_ready) returns one transaction per
// operation with status, read_value, list_length and free_slots.
// Operations run one at a time. The link memory has one read port with a
// registered output, so the walk from the list head follows one link per
// cycle. The walk covers position links for an insert and position minus
// one for a delete or read, at most 61 links; a rejected operation skips it.
// Reset empties the list, clears the count and restores the free chain at
// once through per-slot valid bits, so the block is ready right after reset.
// A finished result waits in the output register while the receiver stalls;
// the next operation is still accepted, and its own result is held in the
// controller until the output register is free.
module cursor_linked_list_engine_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            mode,
  input  logic [cll_pkg::POS_BITS-1:0]          position,
  input  logic signed [cll_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic signed [cll_pkg::VALUE_BITS-1:0] read_value,
  output logic [cll_pkg::COUNT_BITS-1:0]        list_length,
  output logic [cll_pkg::COUNT_BITS-1:0]        free_slots
);
  import cll_pkg::*;

  cll_cmd_t cmd;
  cll_sts_t sts;

  cll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cll_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length),
    .free_slots  (free_slots)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second transaction was accepted while an operation was running.");

  a_read_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == '0))
    else $error("A failed operation returned a nonzero read value.");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (list_length == COUNT_BITS'(CAPACITY)))
    else $error("A full status was reported while the store had room.");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_length <= COUNT_BITS'(CAPACITY)))
    else $error("The list length exceeded the store capacity.");
`endif

endmodule

@@ rtl/cll_ctrl.sv @@
// Controller state machine that sequences the walk, link updates and result transaction.
module cll_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cll_pkg::cll_sts_t  sts,
  output cll_pkg::cll_cmd_t  cmd
);
  import cll_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err_range || (sts.mode == MODE_INSERT && sts.full)) begin
          state_next = S_ERR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_HEAD;
          if (sts.steps_zero) begin
            cmd.prev_head = 1'b1;
            state_next    = S_RA;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = RA_LINK;
        if (sts.left_one) begin
          cmd.prev_link = 1'b1;
          state_next    = S_RA;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_RA: begin
        cmd.ld_a = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_FREE;
          state_next = S_RB;
        end else if (sts.mode == MODE_DELETE) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_LINK;
          state_next = S_RB;
        end else begin
          cmd.data_rd = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_RB: begin
        cmd.rd_en = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          cmd.ld_f   = 1'b1;
          cmd.ra_sel = RA_LINK;
        end else begin
          cmd.ld_b   = 1'b1;
          cmd.ra_sel = RA_FREE;
        end
        state_next = S_RC;
      end
      S_RC: begin
        if (sts.mode == MODE_INSERT) begin
          cmd.ld_b = 1'b1;
        end else begin
          cmd.ld_f = 1'b1;
        end
        state_next = S_W1;
      end
      S_W1: begin
        cmd.wr_en = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          cmd.wa_sel  = WA_FREE;
          cmd.wd_sel  = WD_B;
          cmd.data_wr = 1'b1;
        end else begin
          cmd.wa_sel = WA_PREV;
          cmd.wd_sel = WD_B;
        end
        state_next = S_W2;
      end
      S_W2: begin
        cmd.wr_en = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          cmd.wa_sel = WA_F;
          cmd.wd_sel = WD_A;
        end else begin
          cmd.wa_sel = WA_A;
          cmd.wd_sel = WD_F;
        end
        state_next = S_W3;
      end
      S_W3: begin
        cmd.wr_en = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          cmd.wa_sel  = WA_PREV;
          cmd.wd_sel  = WD_F;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.wa_sel  = WA_FREE;
          cmd.wd_sel  = WD_A;
          cmd.cnt_dec = 1'b1;
        end
        state_next = S_DONE;
      end
      S_ERR: begin
        cmd.out_status = sts.err_range ? ST_RANGE : ST_FULL;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE: begin
        cmd.out_status = ST_OK;
        cmd.out_data   = (sts.mode == MODE_READ);
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/cll_dp.sv @@
// Datapath with the link and data memories, walk registers, element count and result register.
module cll_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          mode,
  input  logic [cll_pkg::POS_BITS-1:0]        position,
  input  logic signed [cll_pkg::VALUE_BITS-1:0] value,
  input  cll_pkg::cll_cmd_t                   cmd,
  output cll_pkg::cll_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          status,
  output logic signed [cll_pkg::VALUE_BITS-1:0] read_value,
  output logic [cll_pkg::COUNT_BITS-1:0]      list_length,
  output logic [cll_pkg::COUNT_BITS-1:0]      free_slots
);
  import cll_pkg::*;

  logic [1:0]                   mode_r;
  logic [POS_BITS-1:0]          pos_r;
  logic signed [VALUE_BITS-1:0] value_r;
  logic [COUNT_BITS-1:0]        count;
  logic [COUNT_BITS-1:0]        left;
  slot_t                        prev;
  slot_t                        a;
  slot_t                        b;
  slot_t                        f;

  slot_t                        link_mem [SLOTS];
  logic [SLOTS-1:0]             link_vld;
  slot_t                        link_raw;
  logic                         link_hit;
  slot_t                        link_addr_q;
  slot_t                        link_q;

  logic signed [DATA_BITS-1:0]  data_mem [SLOTS];
  logic signed [DATA_BITS-1:0]  data_q;

  slot_t                        raddr;
  slot_t                        waddr;
  slot_t                        wdata;
  logic                         pos_over;
  logic                         pos_zero;
  logic [POS_BITS-1:0]          steps_full;
  logic [COUNT_BITS-1:0]        steps;

  assign pos_over   = pos_r > POS_BITS'(count);
  assign pos_zero   = (pos_r == '0);
  assign steps_full = (mode_r == MODE_INSERT) ? pos_r : pos_r - POS_BITS'(1);
  assign steps      = steps_full[COUNT_BITS-1:0];
  assign link_q     = link_hit ? link_raw : reset_link(link_addr_q);

  always_comb begin
    sts.mode       = mode_r;
    sts.full       = (count >= COUNT_BITS'(CAPACITY));
    sts.steps_zero = (steps == '0);
    sts.left_one   = (left == COUNT_BITS'(1));
    sts.out_free   = !out_valid || out_ready;
    if (mode_r == MODE_INSERT) begin
      sts.err_range = pos_over;
    end else if (mode_r == MODE_DELETE || mode_r == MODE_READ) begin
      sts.err_range = pos_zero || pos_over;
    end else begin
      sts.err_range = 1'b1;
    end
  end

  always_comb begin
    case (cmd.ra_sel)
      RA_HEAD: raddr = slot_t'(HEAD_SLOT);
      RA_LINK: raddr = link_q;
      default: raddr = slot_t'(FREE_SLOT);
    endcase
    case (cmd.wa_sel)
      WA_FREE: waddr = slot_t'(FREE_SLOT);
      WA_PREV: waddr = prev;
      WA_A:    waddr = a;
      default: waddr = f;
    endcase
    case (cmd.wd_sel)
      WD_A:    wdata = a;
      WD_B:    wdata = b;
      default: wdata = f;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      link_raw    <= link_mem[raddr];
      link_hit    <= link_vld[raddr];
      link_addr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (cmd.wr_en) begin
      link_vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      data_mem[f] <= DATA_BITS'(value_r);
    end
    if (cmd.data_rd) begin
      data_q <= data_mem[link_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r  <= mode;
      pos_r   <= position;
      value_r <= value;
    end
    if (cmd.prev_head) begin
      prev <= slot_t'(HEAD_SLOT);
    end else if (cmd.prev_link) begin
      prev <= link_q;
    end
    if (cmd.walk_start) begin
      left <= steps;
    end else if (cmd.walk_step) begin
      left <= left - COUNT_BITS'(1);
    end
    if (cmd.ld_a) begin
      a <= link_q;
    end
    if (cmd.ld_b) begin
      b <= link_q;
    end
    if (cmd.ld_f) begin
      f <= link_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + COUNT_BITS'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      read_value  <= cmd.out_data ? VALUE_BITS'(data_q) : '0;
      list_length <= count;
      free_slots  <= COUNT_BITS'(CAPACITY) - count;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the cursor linked list engine with a list model and random traffic.
`timescale 1ns / 100ps

module tb_top;
  import cll_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 1880;
  localparam int WATCHDOG = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]            status;
    logic [31:0]           read_value;
    logic [COUNT_BITS-1:0] list_length;
    logic [COUNT_BITS-1:0] free_slots;
  } outcome_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [POS_BITS-1:0]   pos;
    logic [31:0]           word;
    logic                  typed;
    logic [1:0]            status;
    logic [31:0]           read_value;
    logic [COUNT_BITS-1:0] list_length;
    logic [COUNT_BITS-1:0] free_slots;
  } op_row_t;

  localparam int SCRIPT_ROWS = 23;
  localparam op_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{MODE_READ,   7'd1,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd0, 6'd62},
    '{MODE_DELETE, 7'd0,   32'hFFFF_FFFF, 1'b1, ST_RANGE, 32'h0000_0000, 6'd0, 6'd62},
    '{MODE_INSERT, 7'd1,   32'h1234_5678, 1'b1, ST_RANGE, 32'h0000_0000, 6'd0, 6'd62},
    '{MODE_UNUSED, 7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd0, 6'd62},
    '{MODE_INSERT, 7'd0,   32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000, 6'd1, 6'd61},
    '{MODE_INSERT, 7'd1,   32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000, 6'd2, 6'd60},
    '{MODE_READ,   7'd1,   32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF, 6'd2, 6'd60},
    '{MODE_READ,   7'd2,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h8000_0000, 6'd2, 6'd60},
    '{MODE_READ,   7'd3,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd2, 6'd60},
    '{MODE_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_READ,   7'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_INSERT, 7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd3, 6'd59},
    '{MODE_DELETE, 7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd3, 6'd59},
    '{MODE_READ,   7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd3, 6'd59},
    '{MODE_INSERT, 7'd3,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_DELETE, 7'd2,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_READ,   7'd2,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_UNUSED, 7'd127, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 32'h0000_0000, 6'd3, 6'd59},
    '{MODE_INSERT, 7'd64,  32'h5A5A_5A5A, 1'b1, ST_RANGE, 32'h0000_0000, 6'd3, 6'd59},
    '{MODE_DELETE, 7'd3,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_DELETE, 7'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_DELETE, 7'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 6'd0, 6'd0},
    '{MODE_READ,   7'd1,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 6'd0, 6'd62}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             mode = MODE_INSERT;
  logic [POS_BITS-1:0]    position = '0;
  logic signed [31:0]     value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic signed [31:0]     read_value;
  logic [COUNT_BITS-1:0]  list_length;
  logic [COUNT_BITS-1:0]  free_slots;

  slot_t       model_link [SLOTS];
  logic [31:0] model_word [SLOTS];
  int          stored;
  outcome_t    awaited [$];
  int          errors = 0;
  int          stall_count = 0;
  bit          no_idle = 1'b0;

  cursor_linked_list_engine_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length),
    .free_slots  (free_slots)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic void clear_model();
    for (int i = 0; i < SLOTS; i++) begin
      model_link[i] = (i < CAPACITY) ? slot_t'(i + 1) : slot_t'(0);
      model_word[i] = '0;
    end
    stored = 0;
  endfunction

  function automatic slot_t slot_before(int pos);
    slot_t cur;
    cur = slot_t'(HEAD_SLOT);
    for (int k = 0; k < pos; k++) begin
      cur = model_link[cur];
    end
    return cur;
  endfunction

  function automatic outcome_t apply_op(logic [1:0] op, logic [POS_BITS-1:0] pos,
                                        logic [31:0] word);
    outcome_t res;
    slot_t    prev;
    slot_t    fresh;
    slot_t    gone;
    res = '0;
    res.status = ST_OK;
    case (op)
      MODE_INSERT: begin
        if (pos > stored) begin
          res.status = ST_RANGE;
        end else if (stored >= CAPACITY || model_link[FREE_SLOT] == '0) begin
          res.status = ST_FULL;
        end else begin
          prev = slot_before(int'(pos));
          fresh = model_link[FREE_SLOT];
          model_link[FREE_SLOT] = model_link[fresh];
          model_word[fresh] = word;
          model_link[fresh] = model_link[prev];
          model_link[prev] = fresh;
          stored++;
        end
      end
      MODE_DELETE: begin
        if (pos == 0 || pos > stored) begin
          res.status = ST_RANGE;
        end else begin
          prev = slot_before(int'(pos) - 1);
          gone = model_link[prev];
          model_link[prev] = model_link[gone];
          model_link[gone] = model_link[FREE_SLOT];
          model_link[FREE_SLOT] = gone;
          stored--;
        end
      end
      MODE_READ: begin
        if (pos == 0 || pos > stored) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = model_word[model_link[slot_before(int'(pos) - 1)]];
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.list_length = COUNT_BITS'(stored);
    res.free_slots = COUNT_BITS'(CAPACITY - stored);
    return res;
  endfunction

  task automatic send_op(input logic [1:0] op, input logic [POS_BITS-1:0] pos,
                         input logic [31:0] word, input bit typed, input outcome_t given);
    outcome_t got;
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    position <= pos;
    value <= word;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    got = apply_op(op, pos, word);
    awaited.push_back(typed ? given : got);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: status %0d length %0d", status, list_length);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, read_value);
          errors++;
        end
        if (list_length !== want.list_length) begin
          $error("list_length: expected %0d, actual %0d", want.list_length, list_length);
          errors++;
        end
        if (free_slots !== want.free_slots) begin
          $error("free_slots: expected %0d, actual %0d", want.free_slots, free_slots);
          errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    outcome_t    given;
    logic [1:0]  op;
    logic [6:0]  pos;
    logic [31:0] word;
    bit          growing;
    int unsigned pick;
    clear_model();
    growing = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      given = '{SCRIPT[i].status, SCRIPT[i].read_value, SCRIPT[i].list_length,
                SCRIPT[i].free_slots};
      send_op(SCRIPT[i].mode, SCRIPT[i].pos, SCRIPT[i].word, SCRIPT[i].typed, given);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      no_idle = (n >= 600 && n < 900);
      if (stored == CAPACITY && $urandom_range(3) == 0) begin
        growing = 1'b0;
      end else if (stored == 0 && $urandom_range(3) == 0) begin
        growing = 1'b1;
      end else if ($urandom_range(99) == 0) begin
        growing = !growing;
      end
      word = $urandom;
      pick = $urandom_range(99);
      if (pick < 10) begin
        op = 2'($urandom_range(3));
        pos = 7'($urandom_range(127));
      end else begin
        if (pick < 65) begin
          op = growing ? MODE_INSERT : MODE_DELETE;
        end else if (pick < 80) begin
          op = MODE_READ;
        end else begin
          op = growing ? MODE_DELETE : MODE_INSERT;
        end
        if (op == MODE_INSERT) begin
          pos = 7'($urandom_range(stored));
        end else begin
          pos = (stored == 0) ? 7'd0 : 7'($urandom_range(stored, 1));
        end
      end
      send_op(op, pos, word, 1'b0, '0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (awaited.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
